@@ design/tlpt_pkg.sv @@
// Shared types and constants for the two-level page table.
// Used by tlpt_front, tlpt_back and two_level_page_table; no dependencies.

package tlpt_pkg;

    localparam int PAGE_OFFSET_BITS = 12;
    localparam int DIR_ENTRIES      = 16;
    localparam int TABLE_ENTRIES    = 64;

    localparam int VA_BITS    = 22;
    localparam int FRAME_BITS = 20;
    localparam int PA_BITS    = 32;

    localparam int VPN_BITS      = VA_BITS - PAGE_OFFSET_BITS;
    localparam int TOTAL_ENTRIES = DIR_ENTRIES * TABLE_ENTRIES;
    localparam int DIR_W  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int SLOT_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;

    // Directory index = vpn / TABLE_ENTRIES by rounded-up reciprocal, exact for all vpn.
    localparam int TBL_LOG     = $clog2(TABLE_ENTRIES);
    localparam int RECIP_SHIFT = VPN_BITS + TBL_LOG;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam int PROD_W = VPN_BITS + RECIP_SHIFT + DIR_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [PA_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic
    {
        CMD_MAP   = 1'b0,
        CMD_XLATE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                        cmd;
        logic                        ok;
        logic [DIR_W-1:0]            dir;
        logic [SLOT_W-1:0]           slot;
        logic [PAGE_OFFSET_BITS-1:0] offset;
        logic [FRAME_BITS-1:0]       frame;
    } item_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed
    {
        logic pop;
        logic busy;
    } back_stat_t;

endpackage

@@ design/two_level_page_table.sv @@
// Top level of the two-level page table: front end, item queue and back end.
// Depends on tlpt_pkg, tlpt_front and tlpt_back.
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   virt_addr[21:0], frame_number[41:22]    cmd[0] (0 map, 1 translate)
//  m_axis   out  phys_addr[31:0]                         mapped[0]
//
// The queue head is visible to the back end in the cycle after the accepting edge. A map
// result is registered when its item leaves the queue; a translation result is registered
// from S_LOOKUP, after the table read: the single-port table memory has a registered read.
// A map holds the back end in S_RUN only, a translation also in S_LOOKUP.
// After reset a clearing pass writes all 1024 table entries, one per cycle;
// s_axis_tready stays low while the pass runs.
// A stalled m_axis holds one result while the two-deep queue accepts up to two more words.

module two_level_page_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // virt_addr[21:0], frame_number[41:22]
    input  logic [0:0]  s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // phys_addr[31:0]
    output logic [0:0]  m_axis_tuser    // mapped[0]
);

    tlpt_pkg::head_t      head;
    tlpt_pkg::back_stat_t stat;

    tlpt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .head          (head)
    );

    tlpt_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ design/tlpt_front.sv @@
// Front end: accepts input words, splits the address, queues decoded items.
// Depends on tlpt_pkg.

module tlpt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // virt_addr[21:0], frame_number[41:22]
    input  logic [0:0]            s_axis_tuser,  // cmd[0]
    input  tlpt_pkg::back_stat_t  stat,
    output tlpt_pkg::head_t       head
);

    logic [tlpt_pkg::VA_BITS-1:0]               va;
    logic [tlpt_pkg::VPN_BITS-1:0]              vpn;
    logic [tlpt_pkg::VPN_BITS+tlpt_pkg::SLOT_W-1:0] vpn_ext;
    logic [tlpt_pkg::PROD_W-1:0]                prod;
    tlpt_pkg::item_t                            dec;

    tlpt_pkg::item_t                q_mem [tlpt_pkg::QUEUE_DEPTH];
    logic [tlpt_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tlpt_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tlpt_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           push;

    assign va      = s_axis_tdata[tlpt_pkg::VA_BITS-1:0];
    assign vpn     = va[tlpt_pkg::VA_BITS-1:tlpt_pkg::PAGE_OFFSET_BITS];
    assign vpn_ext = {{tlpt_pkg::SLOT_W{1'b0}}, vpn};
    assign prod    = tlpt_pkg::PROD_W'(vpn) * tlpt_pkg::PROD_W'(tlpt_pkg::RECIP);

    always_comb
    begin
        dec.cmd    = tlpt_pkg::cmd_t'(s_axis_tuser[0]);
        dec.ok     = vpn_ext < (tlpt_pkg::VPN_BITS + tlpt_pkg::SLOT_W)'(tlpt_pkg::TOTAL_ENTRIES);
        dec.dir    = tlpt_pkg::DIR_W'(prod >> tlpt_pkg::RECIP_SHIFT);
        dec.slot   = vpn_ext[tlpt_pkg::SLOT_W-1:0];
        dec.offset = va[tlpt_pkg::PAGE_OFFSET_BITS-1:0];
        dec.frame  = s_axis_tdata[tlpt_pkg::VA_BITS+tlpt_pkg::FRAME_BITS-1:tlpt_pkg::VA_BITS];
    end

    assign s_axis_tready = !stat.busy &&
                           (count_reg != tlpt_pkg::QCNT_W'(tlpt_pkg::QUEUE_DEPTH));
    assign push = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (stat.pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !stat.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && stat.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    assign head.valid = count_reg != '0;
    assign head.item  = q_mem[rd_ptr_reg];

endmodule

@@ design/tlpt_back.sv @@
// Back end: table memory, directory present bits, lookup sequencer, output register.
// Depends on tlpt_pkg; fed by tlpt_front.

module tlpt_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlpt_pkg::head_t       head,
    output tlpt_pkg::back_stat_t  stat,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // phys_addr[31:0]
    output logic [0:0]            m_axis_tuser   // mapped[0]
);

    typedef enum logic [2:0]
    {
        S_CLEAR  = 3'b001,
        S_RUN    = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [tlpt_pkg::FRAME_BITS:0]  mem [tlpt_pkg::TOTAL_ENTRIES];
    logic [tlpt_pkg::FRAME_BITS:0]  rd_data_reg;
    logic [tlpt_pkg::FRAME_BITS:0]  wr_data;
    logic [tlpt_pkg::SLOT_W-1:0]    wr_addr;
    logic                           wr_en;
    logic                           rd_en;

    logic [tlpt_pkg::SLOT_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [tlpt_pkg::DIR_ENTRIES-1:0] dir_present_reg, dir_present_next;
    logic [tlpt_pkg::PAGE_OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                           dirp_reg, dirp_next;

    logic                           out_valid_reg, out_valid_next;
    logic [tlpt_pkg::PA_BITS-1:0]   out_phys_reg, out_phys_next;
    logic                           out_mapped_reg, out_mapped_next;

    logic                           out_free;
    logic                           pop;
    logic                           out_load;
    logic                           hit;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign pop      = (state_reg == S_RUN) && head.valid && out_free;
    assign hit      = dirp_reg && rd_data_reg[tlpt_pkg::FRAME_BITS];

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        dir_present_next = dir_present_reg;
        offset_next      = offset_reg;
        dirp_next        = dirp_reg;
        wr_en            = 1'b0;
        wr_addr          = head.item.slot;
        wr_data          = {1'b1, head.item.frame};
        rd_en            = 1'b0;
        out_load         = 1'b0;
        out_phys_next    = tlpt_pkg::ALL_ONES;
        out_mapped_next  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == tlpt_pkg::SLOT_W'(tlpt_pkg::TOTAL_ENTRIES - 1))
                begin
                    state_next = S_RUN;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_RUN:
            begin
                if (pop)
                begin
                    if (head.item.cmd == tlpt_pkg::CMD_MAP)
                    begin
                        out_load        = 1'b1;
                        out_mapped_next = head.item.ok;
                        if (head.item.ok)
                        begin
                            wr_en = 1'b1;
                            dir_present_next[head.item.dir] = 1'b1;
                        end
                    end
                    else if (head.item.ok)
                    begin
                        rd_en       = 1'b1;
                        offset_next = head.item.offset;
                        dirp_next   = dir_present_reg[head.item.dir];
                        state_next  = S_LOOKUP;
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end
            S_LOOKUP:
            begin
                out_load        = 1'b1;
                out_mapped_next = hit;
                if (hit)
                begin
                    out_phys_next = tlpt_pkg::PA_BITS'(
                        {rd_data_reg[tlpt_pkg::FRAME_BITS-1:0], offset_reg});
                end
                state_next = S_RUN;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            dir_present_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            dir_present_reg <= dir_present_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        dirp_reg   <= dirp_next;
        if (out_load)
        begin
            out_phys_reg   <= out_phys_next;
            out_mapped_reg <= out_mapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head.item.slot];
        end
    end

    assign stat.pop      = pop;
    assign stat.busy     = state_reg == S_CLEAR;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_phys_reg;
    assign m_axis_tuser  = out_mapped_reg;

    // the output slot was freed when the translation left the queue
    a_lookup_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOKUP |-> !out_valid_reg)
        else $error("lookup with output word pending");

    a_lookup_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOKUP |=> out_valid_reg && state_reg == S_RUN)
        else $error("lookup did not load output word");

    a_map_sets_dir: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.item.cmd == tlpt_pkg::CMD_MAP && head.item.ok
        |=> dir_present_reg[$past(head.item.dir)])
        else $error("map left directory absent");

endmodule

@@ tb/tb_two_level_page_table.sv @@
`timescale 1ns / 100ps
// Testbench for two_level_page_table: directed and random map/translate words,
// checked against an in-bench page table walk. Depends on tlpt_pkg and the RTL.

module tb_two_level_page_table;

    import tlpt_pkg::*;

    typedef struct
    {
        cmd_t                  cmd;
        logic [VA_BITS-1:0]    va;
        logic [FRAME_BITS-1:0] frame;
    } pt_request_t;

    typedef struct
    {
        logic [PA_BITS-1:0] phys_addr;
        logic               mapped;
    } pt_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // virt_addr[21:0], frame_number[41:22]
    logic [0:0]  s_axis_tuser;   // cmd[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // phys_addr[31:0]
    logic [0:0]  m_axis_tuser;   // mapped[0]

    pt_request_t request_q[$];
    pt_result_t  expected_q[$];

    bit                    dir_present_m[DIR_ENTRIES];
    bit                    entry_valid_m[TOTAL_ENTRIES];
    logic [FRAME_BITS-1:0] entry_frame_m[TOTAL_ENTRIES];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned mismatches;
    bit          word_taken;
    int unsigned hot_vpn[24];

    two_level_page_table uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Walk the table for one word, updating the shadow state on a map.
    function automatic pt_result_t walk_table(pt_request_t r);
        pt_result_t  res;
        int unsigned vpn;
        int unsigned dir;
        int unsigned slot;
        logic [63:0] pa;
        vpn  = r.va >> PAGE_OFFSET_BITS;
        dir  = vpn / TABLE_ENTRIES;
        slot = dir * TABLE_ENTRIES + vpn % TABLE_ENTRIES;
        res.phys_addr = ALL_ONES;
        res.mapped    = 1'b0;
        if (dir < DIR_ENTRIES)
        begin
            if (r.cmd == CMD_MAP)
            begin
                if (!dir_present_m[dir])
                begin
                    dir_present_m[dir] = 1'b1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        entry_valid_m[dir * TABLE_ENTRIES + i] = 1'b0;
                end
                entry_frame_m[slot] = r.frame;
                entry_valid_m[slot] = 1'b1;
                res.mapped          = 1'b1;
            end
            else if (dir_present_m[dir] && entry_valid_m[slot])
            begin
                pa = (64'(entry_frame_m[slot]) << PAGE_OFFSET_BITS)
                     | 64'(r.va[PAGE_OFFSET_BITS-1:0]);
                res.phys_addr = pa[PA_BITS-1:0];
                res.mapped    = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic push_req(cmd_t cmd, logic [VA_BITS-1:0] va, logic [FRAME_BITS-1:0] frame);
        pt_request_t r;
        r.cmd   = cmd;
        r.va    = va;
        r.frame = frame;
        request_q.push_back(r);
    endtask

    // Mostly a small set of hot pages so translations hit, some fully random addresses.
    task automatic add_random(int n);
        logic [VA_BITS-1:0]    va;
        logic [FRAME_BITS-1:0] frame;
        cmd_t                  cmd;
        for (int i = 0; i < n; i++)
        begin
            va    = VA_BITS'($urandom);
            frame = FRAME_BITS'($urandom);
            if ($urandom_range(99) < 70)
                va[VA_BITS-1:PAGE_OFFSET_BITS] = VPN_BITS'(hot_vpn[$urandom_range(23)]);
            cmd = ($urandom_range(99) < 40) ? CMD_MAP : CMD_XLATE;
            push_req(cmd, va, frame);
            // map followed at once by a lookup of the same page
            if (cmd == CMD_MAP && $urandom_range(3) == 0)
            begin
                va[PAGE_OFFSET_BITS-1:0] = PAGE_OFFSET_BITS'($urandom);
                push_req(CMD_XLATE, va, FRAME_BITS'($urandom));
                i++;
            end
        end
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, int n);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        add_random(n);
        wait_drained();
    endtask

    // driver
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        if (rst_n && (!s_axis_tvalid || word_taken))
        begin : load_next
            pt_request_t r;
            if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                r = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, r.frame, r.va};
                s_axis_tuser  <= r.cmd;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check results first, then predict for the word accepted at this edge
    always @(posedge clk)
    begin : monitor
        pt_result_t  want;
        pt_request_t r;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'h0, m_axis_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata !== want.phys_addr)
                        report_mismatch("phys_addr", want.phys_addr, m_axis_tdata);
                    if (m_axis_tuser[0] !== want.mapped)
                        report_mismatch("mapped", 32'(want.mapped), 32'(m_axis_tuser[0]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.cmd   = cmd_t'(s_axis_tuser[0]);
                r.va    = s_axis_tdata[VA_BITS-1:0];
                r.frame = s_axis_tdata[VA_BITS+FRAME_BITS-1:VA_BITS];
                expected_q.push_back(walk_table(r));
                word_taken = 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        mismatches    = 0;
        foreach (dir_present_m[i])
            dir_present_m[i] = 1'b0;
        foreach (entry_valid_m[i])
            entry_valid_m[i] = 1'b0;
        foreach (hot_vpn[i])
            hot_vpn[i] = $urandom_range(2**VPN_BITS - 1);
        hot_vpn[0] = 0;
        hot_vpn[1] = 2**VPN_BITS - 1;

        // directed: empty table, extremes, remap, same-page back to back
        push_req(CMD_XLATE, 22'h000000, 20'h00000);
        push_req(CMD_XLATE, 22'h3FFFFF, 20'hFFFFF);
        push_req(CMD_MAP,   22'h000000, 20'h00000);
        push_req(CMD_XLATE, 22'h000000, 20'h00000);
        push_req(CMD_XLATE, 22'h000FFF, 20'h00000);
        push_req(CMD_XLATE, 22'h001000, 20'h00000);
        push_req(CMD_MAP,   22'h3FFFFF, 20'hFFFFF);
        push_req(CMD_XLATE, 22'h3FFFFF, 20'h00000);
        push_req(CMD_XLATE, 22'h3FF000, 20'h00000);
        push_req(CMD_XLATE, 22'h3FE123, 20'h00000);
        push_req(CMD_MAP,   22'h2AAAAA, 20'hAAAAA);
        push_req(CMD_XLATE, 22'h2AA555, 20'h55555);
        push_req(CMD_MAP,   22'h155555, 20'h55555);
        push_req(CMD_XLATE, 22'h155AAA, 20'hAAAAA);
        push_req(CMD_MAP,   22'h2AAAAA, 20'h12345);
        push_req(CMD_XLATE, 22'h2AA001, 20'h00000);
        push_req(CMD_MAP,   22'h000000, 20'h80001);
        push_req(CMD_MAP,   22'h000000, 20'h7FFFE);
        push_req(CMD_XLATE, 22'h000ABC, 20'h00000);
        push_req(CMD_MAP,   22'h041000, 20'hFFFFF);
        push_req(CMD_XLATE, 22'h041800, 20'h00000);
        push_req(CMD_XLATE, 22'h042800, 20'h00000);
        push_req(CMD_XLATE, 22'h200000, 20'h00000);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_drained();
        run_phase(0, 0, 100);
        run_phase(60, 0, 100);
        run_phase(0, 60, 100);
        run_phase(33, 33, 100);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
